// ----- design/dwc_pkg.sv -----
// Shared types and constants for the depthwise convolution element.
// No dependencies; used by dwc_store, dwc_mul and depthwise_conv2d_element.
`timescale 1ns / 1ps

package dwc_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] FUNC_PIXEL   = 2'd0;
    localparam logic [1:0] FUNC_WEIGHT  = 2'd1;
    localparam logic [1:0] FUNC_BIAS    = 2'd2;
    localparam logic [1:0] FUNC_COMPUTE = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SCALE  = 3'd6;
    localparam int unsigned CFG_DATA_W = 16;

    // Field widths of the request and the result.
    localparam int unsigned CH_W    = 2;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned SAMP_W  = 16;
    localparam int unsigned OUT_W   = 48;
    localparam int unsigned KDIM_W  = 3;
    localparam int unsigned STR_W   = 3;
    localparam int unsigned IDIM_W  = 6;
    localparam int unsigned SCALE_W = 16;

    // Signed width for tap coordinates in the padded image.
    localparam int unsigned COORD_W = 11;

    // Shared multiplier operand widths. A wide accumulator is split at
    // LO_BITS so each half fits operand A.
    localparam int unsigned MUL_A_W = 20;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int unsigned LO_BITS = 19;

    // Rounding to Q.24 from Q.36.
    localparam int unsigned FRAC_DROP = 12;

    // Write enables toward the stores.
    typedef struct packed {
        logic pix;
        logic ker;
        logic bias;
    } t_store_we;

endpackage

// ----- design/depthwise_conv2d_element.sv -----
// Top level of the depthwise 2D convolution element.
// Depends on dwc_pkg, dwc_store (pixel/kernel/bias stores) and dwc_mul.
`timescale 1ns / 1ps

// Usage: requests arrive on the s_axis channel. tuser selects the kind of
// request: write a pixel, write a kernel weight, write a channel bias, or
// compute one output element at (channel, row, col). Only a compute request
// produces a result on the m_axis channel: the 48-bit Q23.24 value in tdata
// and the out-of-grid flag in tuser.
// Configuration registers are to be written through the plain write port while
// the block is idle; the block itself does not enforce this. They take effect
// at the next request. A write request leaves the block idle. A compute request
// walks the kernel taps one per cycle, as the single shared multiplier and the
// single read port of each store allow, then drains the product pipeline and
// passes through the scale-low, scale-high, scale-add, round and finish steps
// to the result register; an out-of-grid request goes straight to the finish.
// s_axis tready is high only while the sequencer is idle.
// The result sits in an output register, so the next request is accepted
// while an earlier result waits; if the receiver stalls that long, the next
// compute request holds in its final step until the register frees up.
// Reset returns the registers to their defaults and empties the output
// register. Stores are not cleared: pixels, weights and biases must be
// written before a compute request reads them.
module depthwise_conv2d_element #(
    parameter int CHANNELS   = 4,
    parameter int MAX_DIM    = 32,
    parameter int MAX_KERNEL = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [dwc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dwc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Request channel.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata, low bit up: channel[1:0], row[6:2], col[11:7], value[43:12], zero[47:44].
    input  logic [47:0] i_s_axis_tdata,
    // tuser: func[1:0].
    input  logic [1:0]  i_s_axis_tuser,
    // Result channel.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata, low bit up: conv_value[47:0].
    output logic [47:0] o_m_axis_tdata,
    // tuser: out_of_grid[0].
    output logic        o_m_axis_tuser
);

    localparam int PIX_DEPTH = CHANNELS * MAX_DIM * MAX_DIM;
    localparam int KER_DEPTH = CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int KER_AW    = $clog2(KER_DEPTH);
    localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // Each product is at most 2^30 in magnitude; the sum adds tap-count bits.
    localparam int ACC_W     = 32 + $clog2(MAX_KERNEL * MAX_KERNEL + 1);
    localparam int SC_W      = ACC_W + dwc_pkg::MUL_B_W;

    localparam logic signed [SC_W-1:0] SAT_HI =
        SC_W'({1'b0, {(dwc_pkg::OUT_W-1){1'b1}}});
    localparam logic signed [SC_W-1:0] SAT_LO = -SAT_HI - SC_W'(1);
    localparam logic signed [SC_W-1:0] RND_HALF =
        SC_W'(1) <<< (dwc_pkg::FRAC_DROP - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAPS,
        S_DRAIN,
        S_SCALE_LO,
        S_SCALE_HI,
        S_SCALE_ADD,
        S_ROUND,
        S_FINISH
    } t_state;

    // Request fields.
    logic [dwc_pkg::CH_W-1:0]  w_in_ch;
    logic [dwc_pkg::POS_W-1:0] w_in_row;
    logic [dwc_pkg::POS_W-1:0] w_in_col;
    logic [dwc_pkg::VAL_W-1:0] w_in_value;
    logic                      w_accept;

    assign w_in_ch    = i_s_axis_tdata[1:0];
    assign w_in_row   = i_s_axis_tdata[6:2];
    assign w_in_col   = i_s_axis_tdata[11:7];
    assign w_in_value = i_s_axis_tdata[43:12];

    // Configuration registers.
    logic [dwc_pkg::KDIM_W-1:0]  r_cfg_kh;
    logic [dwc_pkg::KDIM_W-1:0]  r_cfg_kw;
    logic [dwc_pkg::STR_W-1:0]   r_cfg_sr;
    logic [dwc_pkg::STR_W-1:0]   r_cfg_sc;
    logic [dwc_pkg::IDIM_W-1:0]  r_cfg_ih;
    logic [dwc_pkg::IDIM_W-1:0]  r_cfg_iw;
    logic [dwc_pkg::SCALE_W-1:0] r_cfg_ws;

    // Sequencer and datapath registers.
    t_state                       r_state;
    logic [dwc_pkg::CH_W-1:0]     r_ch;
    logic signed [dwc_pkg::COORD_W-1:0] r_base_r;
    logic signed [dwc_pkg::COORD_W-1:0] r_base_c;
    logic [dwc_pkg::KDIM_W-1:0]   r_ki;
    logic [dwc_pkg::KDIM_W-1:0]   r_kj;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_oog;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [SC_W-1:0]       r_sc;
    logic signed [SC_W-1:0]       r_q;
    logic                         r_out_valid;
    logic [dwc_pkg::OUT_W-1:0]    r_out_data;
    logic                         r_out_oog;

    // Effective configuration: sizes clamp to the stores, zero stride is one.
    logic [dwc_pkg::KDIM_W-1:0]         w_kh;
    logic [dwc_pkg::KDIM_W-1:0]         w_kw;
    logic [dwc_pkg::STR_W-1:0]          w_sr;
    logic [dwc_pkg::STR_W-1:0]          w_sc;
    logic signed [dwc_pkg::COORD_W-1:0] w_ih;
    logic signed [dwc_pkg::COORD_W-1:0] w_iw;

    assign w_kh = (int'(r_cfg_kh) > MAX_KERNEL) ? dwc_pkg::KDIM_W'(MAX_KERNEL) : r_cfg_kh;
    assign w_kw = (int'(r_cfg_kw) > MAX_KERNEL) ? dwc_pkg::KDIM_W'(MAX_KERNEL) : r_cfg_kw;
    assign w_sr = (r_cfg_sr == '0) ? dwc_pkg::STR_W'(1) : r_cfg_sr;
    assign w_sc = (r_cfg_sc == '0) ? dwc_pkg::STR_W'(1) : r_cfg_sc;
    assign w_ih = (int'(r_cfg_ih) > MAX_DIM) ? dwc_pkg::COORD_W'(MAX_DIM)
                                             : dwc_pkg::COORD_W'(r_cfg_ih);
    assign w_iw = (int'(r_cfg_iw) > MAX_DIM) ? dwc_pkg::COORD_W'(MAX_DIM)
                                             : dwc_pkg::COORD_W'(r_cfg_iw);

    // Request decode. The grid test row < ih / sr is written as
    // (row + 1) * sr <= ih, which avoids a divider.
    logic signed [dwc_pkg::COORD_W-1:0] w_base_r;
    logic signed [dwc_pkg::COORD_W-1:0] w_base_c;
    logic signed [dwc_pkg::COORD_W-1:0] w_row_end;
    logic signed [dwc_pkg::COORD_W-1:0] w_col_end;
    logic                               w_ch_ok;
    logic                               w_in_grid;
    logic                               w_no_taps;

    assign w_base_r  = dwc_pkg::COORD_W'(w_in_row) * dwc_pkg::COORD_W'(w_sr)
                     - dwc_pkg::COORD_W'(w_kh >> 1);
    assign w_base_c  = dwc_pkg::COORD_W'(w_in_col) * dwc_pkg::COORD_W'(w_sc)
                     - dwc_pkg::COORD_W'(w_kw >> 1);
    assign w_row_end = (dwc_pkg::COORD_W'(w_in_row) + dwc_pkg::COORD_W'(1))
                     * dwc_pkg::COORD_W'(w_sr);
    assign w_col_end = (dwc_pkg::COORD_W'(w_in_col) + dwc_pkg::COORD_W'(1))
                     * dwc_pkg::COORD_W'(w_sc);
    assign w_ch_ok   = int'(w_in_ch) < CHANNELS;
    assign w_in_grid = w_ch_ok && (w_row_end <= w_ih) && (w_col_end <= w_iw);
    assign w_no_taps = (w_kh == '0) || (w_kw == '0);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Store writes happen in the acceptance cycle.
    dwc_pkg::t_store_we w_we;
    logic [PIX_AW-1:0]  w_pix_waddr;
    logic [KER_AW-1:0]  w_ker_waddr;

    always_comb begin
        w_we      = '0;
        w_we.pix  = w_accept && (i_s_axis_tuser == dwc_pkg::FUNC_PIXEL) && w_ch_ok
                    && (int'(w_in_row) < MAX_DIM) && (int'(w_in_col) < MAX_DIM);
        w_we.ker  = w_accept && (i_s_axis_tuser == dwc_pkg::FUNC_WEIGHT) && w_ch_ok
                    && (int'(w_in_row) < MAX_KERNEL) && (int'(w_in_col) < MAX_KERNEL);
        w_we.bias = w_accept && (i_s_axis_tuser == dwc_pkg::FUNC_BIAS) && w_ch_ok;
    end

    assign w_pix_waddr = PIX_AW'((int'(w_in_ch) * MAX_DIM + int'(w_in_row)) * MAX_DIM
                                 + int'(w_in_col));
    assign w_ker_waddr = KER_AW'((int'(w_in_ch) * MAX_KERNEL + int'(w_in_row)) * MAX_KERNEL
                                 + int'(w_in_col));

    // Tap walk: the current tap's position in the image and its store addresses.
    logic signed [dwc_pkg::COORD_W-1:0] w_tr;
    logic signed [dwc_pkg::COORD_W-1:0] w_tc;
    logic                               w_tap_in;
    logic                               w_last_tap;
    logic [PIX_AW-1:0]                  w_pix_raddr;
    logic [KER_AW-1:0]                  w_ker_raddr;

    assign w_tr       = r_base_r + dwc_pkg::COORD_W'(r_ki);
    assign w_tc       = r_base_c + dwc_pkg::COORD_W'(r_kj);
    // Taps that land in the zero padding are skipped, not summed.
    assign w_tap_in   = (w_tr >= 0) && (w_tr < w_ih) && (w_tc >= 0) && (w_tc < w_iw);
    assign w_last_tap = (r_ki == w_kh - dwc_pkg::KDIM_W'(1))
                     && (r_kj == w_kw - dwc_pkg::KDIM_W'(1));
    assign w_pix_raddr = PIX_AW'((int'(r_ch) * MAX_DIM + int'(w_tr)) * MAX_DIM + int'(w_tc));
    assign w_ker_raddr = KER_AW'((int'(r_ch) * MAX_KERNEL + int'(r_ki)) * MAX_KERNEL
                                 + int'(r_kj));

    logic [dwc_pkg::SAMP_W-1:0] w_pix_q;
    logic [dwc_pkg::SAMP_W-1:0] w_ker_q;
    logic [dwc_pkg::VAL_W-1:0]  w_bias;

    dwc_store #(
        .CHANNELS   (CHANNELS),
        .MAX_DIM    (MAX_DIM),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (w_we),
        .i_pix_waddr (w_pix_waddr),
        .i_ker_waddr (w_ker_waddr),
        .i_bias_wsel (CH_AW'(w_in_ch)),
        .i_wdata     (w_in_value),
        .i_pix_raddr (w_pix_raddr),
        .i_ker_raddr (w_ker_raddr),
        .i_bias_rsel (CH_AW'(r_ch)),
        .o_pix_q     (w_pix_q),
        .o_ker_q     (w_ker_q),
        .o_bias      (w_bias)
    );

    // Shared multiplier operands. During the tap walk it forms pixel times
    // weight; afterwards it scales the sum in two halves: the unsigned low
    // LO_BITS bits first, then the signed upper part.
    logic signed [dwc_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [dwc_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [dwc_pkg::MUL_P_W-1:0] w_mul_p;
    logic signed [ACC_W-1:0]            w_acc_hi;
    logic signed [dwc_pkg::MUL_B_W-1:0] w_scale_op;

    assign w_acc_hi   = r_acc >>> dwc_pkg::LO_BITS;
    assign w_scale_op = dwc_pkg::MUL_B_W'({1'b0, r_cfg_ws});

    always_comb begin
        case (r_state)
            S_SCALE_LO: begin
                w_mul_a = dwc_pkg::MUL_A_W'({1'b0, r_acc[dwc_pkg::LO_BITS-1:0]});
                w_mul_b = w_scale_op;
            end
            S_SCALE_HI: begin
                w_mul_a = dwc_pkg::MUL_A_W'(w_acc_hi);
                w_mul_b = w_scale_op;
            end
            default: begin
                w_mul_a = dwc_pkg::MUL_A_W'($signed(w_pix_q));
                w_mul_b = dwc_pkg::MUL_B_W'($signed(w_ker_q));
            end
        endcase
    end

    dwc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // Final steps: round half up to Q.24, add the bias, saturate to 48 bits.
    logic signed [SC_W-1:0] w_prod_ext;
    logic signed [SC_W-1:0] w_rounded;
    logic signed [SC_W-1:0] w_sum;
    logic signed [SC_W-1:0] w_sat;

    assign w_prod_ext = SC_W'(w_mul_p);
    assign w_rounded  = (r_sc + RND_HALF) >>> dwc_pkg::FRAC_DROP;
    assign w_sum      = r_q + SC_W'($signed(w_bias));
    assign w_sat      = (w_sum > SAT_HI) ? SAT_HI : ((w_sum < SAT_LO) ? SAT_LO : w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_kh    <= dwc_pkg::KDIM_W'(3);
            r_cfg_kw    <= dwc_pkg::KDIM_W'(3);
            r_cfg_sr    <= dwc_pkg::STR_W'(1);
            r_cfg_sc    <= dwc_pkg::STR_W'(1);
            r_cfg_ih    <= dwc_pkg::IDIM_W'(32);
            r_cfg_iw    <= dwc_pkg::IDIM_W'(32);
            r_cfg_ws    <= dwc_pkg::SCALE_W'(4096);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dwc_pkg::CFG_KERNEL_HEIGHT: r_cfg_kh <= i_cfg_wdata[dwc_pkg::KDIM_W-1:0];
                    dwc_pkg::CFG_KERNEL_WIDTH:  r_cfg_kw <= i_cfg_wdata[dwc_pkg::KDIM_W-1:0];
                    dwc_pkg::CFG_STRIDE_ROWS:   r_cfg_sr <= i_cfg_wdata[dwc_pkg::STR_W-1:0];
                    dwc_pkg::CFG_STRIDE_COLS:   r_cfg_sc <= i_cfg_wdata[dwc_pkg::STR_W-1:0];
                    dwc_pkg::CFG_IMAGE_HEIGHT:  r_cfg_ih <= i_cfg_wdata[dwc_pkg::IDIM_W-1:0];
                    dwc_pkg::CFG_IMAGE_WIDTH:   r_cfg_iw <= i_cfg_wdata[dwc_pkg::IDIM_W-1:0];
                    dwc_pkg::CFG_WEIGHT_SCALE:  r_cfg_ws <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Product pipeline: the read issues with r_v1, the product lands
            // with r_v2 and is summed on that edge.
            r_v1 <= 1'b0;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(w_mul_p);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_s_axis_tuser == dwc_pkg::FUNC_COMPUTE)) begin
                        r_ch     <= w_in_ch;
                        r_base_r <= w_base_r;
                        r_base_c <= w_base_c;
                        r_ki     <= '0;
                        r_kj     <= '0;
                        r_acc    <= '0;
                        r_oog    <= !w_in_grid;
                        if (!w_in_grid) begin
                            r_state <= S_FINISH;
                        end else if (w_no_taps) begin
                            r_state <= S_SCALE_LO;
                        end else begin
                            r_state <= S_TAPS;
                        end
                    end
                end
                S_TAPS: begin
                    r_v1 <= w_tap_in;
                    if (w_last_tap) begin
                        r_state <= S_DRAIN;
                    end else if (r_kj == w_kw - dwc_pkg::KDIM_W'(1)) begin
                        r_kj <= '0;
                        r_ki <= r_ki + dwc_pkg::KDIM_W'(1);
                    end else begin
                        r_kj <= r_kj + dwc_pkg::KDIM_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_SCALE_LO;
                    end
                end
                S_SCALE_LO: begin
                    r_state <= S_SCALE_HI;
                end
                S_SCALE_HI: begin
                    r_sc    <= w_prod_ext;
                    r_state <= S_SCALE_ADD;
                end
                S_SCALE_ADD: begin
                    r_sc    <= r_sc + (w_prod_ext <<< dwc_pkg::LO_BITS);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_q     <= w_rounded;
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // Wait here while an earlier result is still held.
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_oog   <= r_oog;
                        r_out_data  <= r_oog ? '0 : w_sat[dwc_pkg::OUT_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_oog;

    // An out-of-grid result always carries a zero value.
    a_oog_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("out-of-grid result with nonzero value");

    // Products are only in flight during the tap walk and its drain.
    a_mac_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_TAPS || r_state == S_DRAIN))
        else $error("product pending outside the tap walk");

    // A store write leaves the block idle in the following cycle.
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_s_axis_tuser != dwc_pkg::FUNC_COMPUTE) |=> r_state == S_IDLE)
        else $error("write request did not return to idle");

    // The scaling steps start only once the accumulator has settled.
    a_scale_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE_LO) |-> !r_v1 && !r_v2)
        else $error("scaling began with products in flight");

endmodule

// ----- design/dwc_store.sv -----
// Pixel, kernel and bias stores of the depthwise convolution element.
// Depends on dwc_pkg for field widths and the write enable struct.
`timescale 1ns / 1ps

module dwc_store #(
    parameter int CHANNELS   = 4,
    parameter int MAX_DIM    = 32,
    parameter int MAX_KERNEL = 7
) (
    input  logic                           i_clk,
    input  dwc_pkg::t_store_we             i_we,
    input  logic [$clog2(CHANNELS*MAX_DIM*MAX_DIM)-1:0]       i_pix_waddr,
    input  logic [$clog2(CHANNELS*MAX_KERNEL*MAX_KERNEL)-1:0] i_ker_waddr,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_bias_wsel,
    input  logic [dwc_pkg::VAL_W-1:0]      i_wdata,
    input  logic [$clog2(CHANNELS*MAX_DIM*MAX_DIM)-1:0]       i_pix_raddr,
    input  logic [$clog2(CHANNELS*MAX_KERNEL*MAX_KERNEL)-1:0] i_ker_raddr,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_bias_rsel,
    output logic [dwc_pkg::SAMP_W-1:0]     o_pix_q,
    output logic [dwc_pkg::SAMP_W-1:0]     o_ker_q,
    output logic [dwc_pkg::VAL_W-1:0]      o_bias
);

    localparam int PIX_DEPTH = CHANNELS * MAX_DIM * MAX_DIM;
    localparam int KER_DEPTH = CHANNELS * MAX_KERNEL * MAX_KERNEL;

    logic [dwc_pkg::SAMP_W-1:0] r_pix_mem [PIX_DEPTH];
    logic [dwc_pkg::SAMP_W-1:0] r_ker_mem [KER_DEPTH];
    logic [dwc_pkg::VAL_W-1:0]  r_bias [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (i_we.pix) begin
            r_pix_mem[i_pix_waddr] <= i_wdata[dwc_pkg::SAMP_W-1:0];
        end
        o_pix_q <= r_pix_mem[i_pix_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.ker) begin
            r_ker_mem[i_ker_waddr] <= i_wdata[dwc_pkg::SAMP_W-1:0];
        end
        o_ker_q <= r_ker_mem[i_ker_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.bias) begin
            r_bias[i_bias_wsel] <= i_wdata;
        end
    end

    assign o_bias = r_bias[i_bias_rsel];

endmodule

// ----- design/dwc_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on dwc_pkg for operand widths.
`timescale 1ns / 1ps

module dwc_mul (
    input  logic                               i_clk,
    input  logic signed [dwc_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [dwc_pkg::MUL_B_W-1:0] i_b,
    output logic signed [dwc_pkg::MUL_P_W-1:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= dwc_pkg::MUL_P_W'(i_a * i_b);
    end

endmodule
